/* rtl/msp_pkg.sv */
// Shared types, register indexes and helper functions for the moving sphere potential core.
// No dependencies; every other file in rtl imports this package.
package msp_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int CFG_INDEX_W       = 3;
	localparam int CFG_DATA_W        = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Z      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_X    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_Y    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_Z    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_MASS  = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_RADIUS        = 3'd7;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] sim_time;
	} in_t;

	typedef struct packed {
		logic signed [31:0] potential;
		logic               inside_sphere;
	} out_t;

	typedef struct packed {
		logic signed [31:0] cen_x;
		logic signed [31:0] cen_y;
		logic signed [31:0] cen_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [30:0]        gm;
		logic [30:0]        rad;
	} cfg_t;

	// Floor of three quarters of x, without forming 3x.
	function automatic logic [63:0] three_quarters(input logic [63:0] x);
		logic [63:0] base;
		logic [1:0]  frac;
		begin
			base = {2'b00, x[63:2]};
			unique case (x[1:0])
				2'd0: frac = 2'd0;
				2'd1: frac = 2'd0;
				2'd2: frac = 2'd1;
				2'd3: frac = 2'd2;
				default: frac = 2'd0;
			endcase
			three_quarters = base + {base[62:0], 1'b0} + {62'd0, frac};
		end
	endfunction

endpackage

/* rtl/msp_front.sv */
// Front stages: moving centre, offset vector, common scaling and sum of squares.
// Depends on msp_pkg.
module msp_front #(
	parameter int FRACTION_BITS = msp_pkg::FRACTION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         in_valid,
	input  msp_pkg::in_t in_data,
	input  msp_pkg::cfg_t cfg,
	output logic         out_valid,
	output logic [63:0]  out_sum,
	output logic [6:0]   out_shift
);
	import msp_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [63:0] prod_s1 [3];
	logic signed [31:0] pos_s1  [3];
	logic signed [65:0] d_s2    [3];
	logic [64:0]        mag_s3  [3];
	logic [64:0]        or_s3;
	logic [64:0]        mag_s4  [3];
	logic [6:0]         sh_s4;
	logic [30:0]        a_s5    [3];
	logic [6:0]         sh_s5;
	logic [61:0]        sq_s6   [3];
	logic [6:0]         sh_s6;
	logic [63:0]        sum_s7;
	logic [6:0]         sh_s7;

	logic signed [31:0] pos_in [3];
	logic signed [31:0] vel    [3];
	logic signed [31:0] cen    [3];
	logic [6:0]         bitlen;
	logic [6:0]         sh_c;

	assign pos_in[0] = in_data.pos_x;
	assign pos_in[1] = in_data.pos_y;
	assign pos_in[2] = in_data.pos_z;
	assign vel[0]    = cfg.vel_x;
	assign vel[1]    = cfg.vel_y;
	assign vel[2]    = cfg.vel_z;
	assign cen[0]    = cfg.cen_x;
	assign cen[1]    = cfg.cen_y;
	assign cen[2]    = cfg.cen_z;

	// The length of the OR of the magnitudes equals the length of the largest one.
	always_comb begin
		bitlen = '0;
		for (int i = 0; i < 65; i++) begin
			if (or_s3[i]) begin
				bitlen = 7'(i + 1);
			end
		end
		sh_c = (bitlen > 7'd31) ? 7'(bitlen - 7'd31) : 7'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= 64'(in_data.sim_time) * 64'(vel[i]);
				pos_s1[i]  <= pos_in[i];
				d_s2[i]    <= 66'(pos_s1[i]) - 66'(cen[i]) - 66'(prod_s1[i] >>> FRACTION_BITS);
				mag_s3[i]  <= d_s2[i][65] ? 65'($unsigned(-d_s2[i])) : 65'($unsigned(d_s2[i]));
				mag_s4[i]  <= mag_s3[i];
				a_s5[i]    <= 31'(mag_s4[i] >> sh_s4);
				sq_s6[i]   <= 62'(a_s5[i]) * 62'(a_s5[i]);
			end
			or_s3  <= 65'($unsigned(d_s2[0][65] ? -d_s2[0] : d_s2[0]))
			        | 65'($unsigned(d_s2[1][65] ? -d_s2[1] : d_s2[1]))
			        | 65'($unsigned(d_s2[2][65] ? -d_s2[2] : d_s2[2]));
			sh_s4  <= sh_c;
			sh_s5  <= sh_s4;
			sh_s6  <= sh_s5;
			sum_s7 <= 64'(sq_s6[0]) + 64'(sq_s6[1]) + 64'(sq_s6[2]);
			sh_s7  <= sh_s6;
		end
	end

	assign out_valid = v_s7;
	assign out_sum   = sum_s7;
	assign out_shift = sh_s7;

endmodule

/* rtl/msp_sqrt.sv */
// Integer square root, one result bit per pipeline stage (32 stages).
// Depends on msp_pkg.
module msp_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  logic [63:0] radicand,
	input  logic [6:0]  in_shift,
	output logic        out_valid,
	output logic [31:0] root,
	output logic [6:0]  out_shift
);
	import msp_pkg::*;

	localparam int STEPS = 32;

	typedef struct packed {
		logic [63:0] v;
		logic [33:0] rem;
		logic [31:0] root;
		logic [6:0]  sh;
	} sq_t;

	sq_t  stage_s [STEPS+1];
	logic vld_s   [STEPS+1];

	always_comb begin
		stage_s[0].v    = radicand;
		stage_s[0].rem  = '0;
		stage_s[0].root = '0;
		stage_s[0].sh   = in_shift;
		vld_s[0]        = in_valid;
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [35:0] rem2;
		logic [35:0] test;
		logic        ge;
		sq_t         nxt;

		always_comb begin
			rem2     = {stage_s[k].rem, stage_s[k].v[63:62]};
			test     = {2'b00, stage_s[k].root, 2'b01};
			ge       = rem2 >= test;
			nxt.v    = {stage_s[k].v[61:0], 2'b00};
			nxt.rem  = ge ? 34'(rem2 - test) : 34'(rem2);
			nxt.root = {stage_s[k].root[30:0], ge};
			nxt.sh   = stage_s[k].sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stage_s[k+1] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign root      = stage_s[STEPS].root;
	assign out_shift = stage_s[STEPS].sh;

endmodule

/* rtl/msp_div.sv */
// Distance setup and three restoring dividers run side by side, one quotient bit per stage:
// GM/R, GM/r and the scaled inner ratio (R^2 - r^2)/R^2. Depends on msp_pkg.
module msp_div #(
	parameter int FRACTION_BITS = msp_pkg::FRACTION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_valid,
	input  logic [31:0]               root,
	input  logic [6:0]                in_shift,
	input  logic [30:0]               gm,
	input  logic [30:0]               rad_eff,
	input  logic [61:0]               rad_sq,
	output logic                      out_valid,
	output logic [31+FRACTION_BITS-1:0] h_quo,
	output logic [31+FRACTION_BITS-1:0] r_quo,
	output logic [30:0]               e_quo,
	output logic                      in_sphere
);
	import msp_pkg::*;

	localparam int NW     = 31 + FRACTION_BITS;
	localparam int E_BITS = 31;

	typedef struct packed {
		logic          in_sph;
		logic [65:0]   rho;
		logic [30:0]   remh;
		logic [NW-1:0] qh;
		logic [65:0]   remq;
		logic [NW-1:0] qq;
		logic [61:0]   reme;
		logic [30:0]   e;
	} dv_t;

	logic [NW-1:0] gm_num;
	assign gm_num = {gm, FRACTION_BITS'(0)};

	logic        v_s1, v_s2, v_s3;
	logic [65:0] rho_s1, rho_s2, rho_s3;
	logic        in_s1, in_s2, in_s3;
	logic [30:0] rt_s1;
	logic [61:0] rho2_s2;
	logic [61:0] w_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// A point scaled down before the root is always far outside the sphere.
	always_ff @(posedge clk) begin
		if (adv) begin
			rho_s1  <= 66'(root) << in_shift;
			in_s1   <= (in_shift == 7'd0) && ({1'b0, root} < 33'(rad_eff));
			rt_s1   <= root[30:0];
			rho_s2  <= rho_s1;
			in_s2   <= in_s1;
			rho2_s2 <= 62'(rt_s1) * 62'(rt_s1);
			rho_s3  <= rho_s2;
			in_s3   <= in_s2;
			w_s3    <= in_s2 ? 62'(rad_sq - rho2_s2) : 62'd0;
		end
	end

	dv_t  dv_s  [NW+1];
	logic dvv_s [NW+1];

	always_comb begin
		dv_s[0].in_sph = in_s3;
		dv_s[0].rho    = rho_s3;
		dv_s[0].remh   = '0;
		dv_s[0].qh     = '0;
		dv_s[0].remq   = '0;
		dv_s[0].qq     = '0;
		dv_s[0].reme   = w_s3;
		dv_s[0].e      = '0;
		dvv_s[0]       = v_s3;
	end

	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [31:0] th;
		logic        geh;
		logic [66:0] tq;
		logic        geq;
		logic [62:0] te;
		logic        gee;
		dv_t         nxt;

		always_comb begin
			th  = {dv_s[k].remh, gm_num[NW-1-k]};
			geh = th >= {1'b0, rad_eff};
			tq  = {dv_s[k].remq, gm_num[NW-1-k]};
			geq = tq >= {1'b0, dv_s[k].rho};
			te  = {dv_s[k].reme, 1'b0};
			gee = te >= {1'b0, rad_sq};
			nxt        = dv_s[k];
			nxt.remh   = geh ? 31'(th - {1'b0, rad_eff}) : th[30:0];
			nxt.qh     = {dv_s[k].qh[NW-2:0], geh};
			nxt.remq   = geq ? 66'(tq - {1'b0, dv_s[k].rho}) : tq[65:0];
			nxt.qq     = {dv_s[k].qq[NW-2:0], geq};
			if (k < E_BITS) begin
				nxt.reme = gee ? 62'(te - {1'b0, rad_sq}) : te[61:0];
				nxt.e    = {dv_s[k].e[29:0], gee};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[k+1] <= 1'b0;
			end else if (adv) begin
				dvv_s[k+1] <= dvv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	assign out_valid = dvv_s[NW];
	assign h_quo     = dv_s[NW].qh;
	assign r_quo     = dv_s[NW].qq;
	assign e_quo     = dv_s[NW].e;
	assign in_sphere = dv_s[NW].in_sph;

endmodule

/* rtl/msp_back.sv */
// Back stages: offset, inner product term, branch select and saturation into the output register.
// Depends on msp_pkg.
module msp_back #(
	parameter int FRACTION_BITS = msp_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [31+FRACTION_BITS-1:0] h_quo,
	input  logic [31+FRACTION_BITS-1:0] r_quo,
	input  logic [30:0]                 e_quo,
	input  logic                        in_sphere,
	output logic                        out_valid,
	output msp_pkg::out_t               out_data
);
	import msp_pkg::*;

	localparam int NW = 31 + FRACTION_BITS;
	localparam int PW = NW + 2;
	localparam logic [NW-1:0] H_CLAMP = NW'(64'd1 << 33);
	localparam logic signed [PW-1:0] SAT_MAX = PW'(64'sd2147483647);
	localparam logic signed [PW-1:0] SAT_MIN = PW'(-64'sd2147483648);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [33:0]            hc_s1, hc_s2;
	logic [NW-1:0]          tqh_s1, q_s1;
	logic [30:0]            e_s1;
	logic                   in_s1, in_s2, in_s3, in_s4;
	logic [47:0]            pl_s2, ph_s2;
	logic [33:0]            tqhc_s2;
	logic signed [PW-1:0]   outer_s2, outer_s3;
	logic [32:0]            m_s3;
	logic signed [35:0]     inner_s3;
	logic signed [PW-1:0]   pot_s4;
	out_t                   res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hc_s1    <= (h_quo > H_CLAMP) ? {1'b1, 33'd0} : 34'(h_quo);
			tqh_s1   <= NW'(three_quarters(64'(h_quo)));
			q_s1     <= r_quo;
			e_s1     <= e_quo;
			in_s1    <= in_sphere;

			// The 34 by 31 bit product is split into two 17-bit halves of hc.
			pl_s2    <= 48'(hc_s1[16:0]) * 48'(e_s1);
			ph_s2    <= 48'(hc_s1[33:17]) * 48'(e_s1);
			tqhc_s2  <= 34'(three_quarters(64'(hc_s1)));
			hc_s2    <= hc_s1;
			outer_s2 <= $signed({2'b00, tqh_s1}) - $signed({2'b00, q_s1});
			in_s2    <= in_s1;

			m_s3     <= 33'(((66'(ph_s2) << 17) + 66'(pl_s2)) >> 32);
			inner_s3 <= $signed({2'b00, tqhc_s2}) - $signed({2'b00, hc_s2});
			outer_s3 <= outer_s2;
			in_s3    <= in_s2;

			pot_s4   <= in_s3 ? (PW'(inner_s3) - $signed(PW'(m_s3))) : outer_s3;
			in_s4    <= in_s3;

			if (pot_s4 > SAT_MAX) begin
				res_s5.potential <= 32'sh7FFF_FFFF;
			end else if (pot_s4 < SAT_MIN) begin
				res_s5.potential <= 32'sh8000_0000;
			end else begin
				res_s5.potential <= 32'(pot_s4);
			end
			res_s5.inside_sphere <= in_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

endmodule

/* rtl/moving_uniform_sphere_potential_core.sv */
// Depth comes mostly from the 32-stage square root and the one-bit-per-stage dividers.
// Throughput: one request per cycle; a stalled output holds the whole pipeline in place.
// Reset clears all valid bits and loads the register defaults (centre and velocity zero,
// mass term and radius one). Depends on msp_pkg, msp_front, msp_sqrt, msp_div, msp_back.
module moving_uniform_sphere_potential_core #(
	parameter int FRACTION_BITS = msp_pkg::FRACTION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  msp_pkg::in_t                     in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output msp_pkg::out_t                    out_data,
	input  logic                             cfg_we,
	input  logic [msp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [msp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import msp_pkg::*;

	localparam int NW = 31 + FRACTION_BITS;

	cfg_t        cfg_q;
	logic [30:0] rad_eff;
	logic [61:0] rad_sq_q;
	logic        adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cen_x <= '0;
			cfg_q.cen_y <= '0;
			cfg_q.cen_z <= '0;
			cfg_q.vel_x <= '0;
			cfg_q.vel_y <= '0;
			cfg_q.vel_z <= '0;
			cfg_q.gm    <= 31'd65536;
			cfg_q.rad   <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X:      cfg_q.cen_x <= cfg_data;
				REG_CENTER_Y:      cfg_q.cen_y <= cfg_data;
				REG_CENTER_Z:      cfg_q.cen_z <= cfg_data;
				REG_VELOCITY_X:    cfg_q.vel_x <= cfg_data;
				REG_VELOCITY_Y:    cfg_q.vel_y <= cfg_data;
				REG_VELOCITY_Z:    cfg_q.vel_z <= cfg_data;
				REG_GRAVITY_MASS:  cfg_q.gm    <= cfg_data[30:0];
				REG_RADIUS:        cfg_q.rad   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// A zero radius behaves as one least significant bit.
	assign rad_eff = (cfg_q.rad == 31'd0) ? 31'd1 : cfg_q.rad;

	// Follows the radius every cycle; it is read long after any request enters.
	always_ff @(posedge clk) begin
		rad_sq_q <= 62'(rad_eff) * 62'(rad_eff);
	end

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	logic          f_valid;
	logic [63:0]   f_sum;
	logic [6:0]    f_shift;
	logic          r_valid;
	logic [31:0]   r_root;
	logic [6:0]    r_shift;
	logic          d_valid;
	logic [NW-1:0] d_h;
	logic [NW-1:0] d_q;
	logic [30:0]   d_e;
	logic          d_inside;

	msp_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.out_valid (f_valid),
		.out_sum   (f_sum),
		.out_shift (f_shift)
	);

	msp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (f_valid),
		.radicand  (f_sum),
		.in_shift  (f_shift),
		.out_valid (r_valid),
		.root      (r_root),
		.out_shift (r_shift)
	);

	msp_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (r_valid),
		.root      (r_root),
		.in_shift  (r_shift),
		.gm        (cfg_q.gm),
		.rad_eff   (rad_eff),
		.rad_sq    (rad_sq_q),
		.out_valid (d_valid),
		.h_quo     (d_h),
		.r_quo     (d_q),
		.e_quo     (d_e),
		.in_sphere (d_inside)
	);

	msp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (d_valid),
		.h_quo     (d_h),
		.r_quo     (d_q),
		.e_quo     (d_e),
		.in_sphere (d_inside),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

/* rtl/msp_checker.sv */
// Port-level checks for the moving sphere potential core, bound to the top level.
// Depends on msp_pkg and moving_uniform_sphere_potential_core.
module msp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input msp_pkg::in_t                     in_data,
	input logic                             out_valid,
	input logic                             out_stall,
	input msp_pkg::out_t                    out_data
);
	import msp_pkg::*;

	// A held result stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A refused request is offered again unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("request changed while stalled");

	// Requests are refused only while a finished result waits.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	// The inner formula never gives a positive potential.
	a_inside_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.inside_sphere |-> out_data.potential <= 0)
		else $error("positive potential inside the sphere");

endmodule

bind moving_uniform_sphere_potential_core msp_checker u_msp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* bench/moving_uniform_sphere_potential_core_tb.sv */
// Self-checking bench for the moving sphere potential core: directed rows, then random requests.
// Each accepted request is predicted in the bench and checked in order. Depends on msp_pkg.
module moving_uniform_sphere_potential_core_tb;
	import msp_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 78 + FB;
	localparam int WATCHDOG_LIMIT = 20 * (LATENCY + 40);

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	moving_uniform_sphere_potential_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Bench copy of the registers.
	logic signed [31:0] m_cen [3];
	logic signed [31:0] m_vel [3];
	logic [30:0] m_gm;
	logic [30:0] m_rad;

	out_t potential_q [$];
	int errors = 0;
	int idle_cycles = 0;
	bit stim_done = 0;

	typedef struct {
		in_t req;
		bit known;
		out_t res;
	} row_t;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] quarter3(input logic [63:0] x);
		return 3 * (x >> 2) + (3 * (x & 64'd3)) / 4;
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic out_t sphere_potential(input in_t p);
		logic signed [63:0] d, t, pos [3], vt;
		logic [63:0] mag [3], m, sum, rho, rad, h, gmn, a, r2, w, rem, e, hc;
		logic signed [63:0] pot;
		int s;
		bit ins;
		out_t o;
		pos[0] = p.pos_x; pos[1] = p.pos_y; pos[2] = p.pos_z;
		t = p.sim_time;
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			vt = 64'(m_vel[i]) * t;
			d = pos[i] - 64'(m_cen[i]) - (vt >>> FB);
			mag[i] = d < 0 ? -d : d;
			if (mag[i] > m) m = mag[i];
		end
		s = 0;
		while ((m >> s) >= 64'h8000_0000) s++;
		for (int i = 0; i < 3; i++) begin
			a = mag[i] >> s;
			sum += a * a;
		end
		rho = root64(sum) << s;
		rad = m_rad == 0 ? 64'd1 : 64'(m_rad);
		gmn = 64'(m_gm) << FB;
		h = gmn / rad;
		ins = (s == 0) && (rho < rad);
		if (!ins) begin
			pot = $signed(quarter3(h)) - $signed(gmn / rho);
		end else begin
			r2 = rad * rad;
			w = r2 - rho * rho;
			rem = w;
			e = 0;
			hc = h > (64'd1 << 33) ? (64'd1 << 33) : h;
			for (int i = 0; i < 31; i++) begin
				rem <<= 1;
				e <<= 1;
				if (rem >= r2) begin
					rem -= r2;
					e |= 1;
				end
			end
			pot = $signed(quarter3(hc)) - $signed(hc) - $signed((hc * e) >> 32);
		end
		if (pot > 64'sd2147483647) pot = 64'sd2147483647;
		if (pot < -64'sd2147483648) pot = -64'sd2147483648;
		o.potential = pot[31:0];
		o.inside_sphere = ins;
		return o;
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx <= REG_CENTER_Z) m_cen[idx] = val;
		else if (idx <= REG_VELOCITY_Z) m_vel[idx - REG_VELOCITY_X] = val;
		else if (idx == REG_GRAVITY_MASS) m_gm = val[30:0];
		else m_rad = val[30:0];
	endtask

	// Waits until every outstanding result has come back, then for the pipeline depth.
	task automatic drain();
		in_valid <= 0;
		while (potential_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// The valid line stays high after a request unless the next one waits.
	task automatic send(input in_t req, input bit known, input out_t res);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		potential_q.push_back(known ? res : sphere_potential(req));
		@(negedge clk);
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
			default: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
		endcase
	endfunction

	task automatic random_phase(input int n);
		in_t r;
		out_t dummy;
		dummy = '0;
		for (int i = 0; i < n; i++) begin
			r.pos_x = rnd_coord();
			r.pos_y = rnd_coord();
			r.pos_z = rnd_coord();
			r.sim_time = ($urandom_range(0, 3) == 0) ? $urandom() : rnd_coord();
			send(r, 0, dummy);
		end
	endtask

	// Output side: a random wait before each result, check in order.
	initial begin
		out_t got, exp_r;
		int wait_n;
		out_stall = 1;
		@(negedge clk);
		forever begin
			wait_n = $urandom_range(0, 10);
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(arst_n && out_valid)) @(posedge clk);
			got = out_data;
			if (potential_q.size() == 0) begin
				$error("result with no request outstanding: potential %0d", got.potential);
				errors++;
			end else begin
				exp_r = potential_q.pop_front();
				if (got.potential !== exp_r.potential) begin
					$error("potential: expected %0d, got %0d", exp_r.potential,
						got.potential);
					errors++;
				end
				if (got.inside_sphere !== exp_r.inside_sphere) begin
					$error("inside_sphere: expected %0b, got %0b",
						exp_r.inside_sphere, got.inside_sphere);
					errors++;
				end
			end
			@(negedge clk);
		end
	end

	// Watchdog on cycles with no accepted request and no taken result.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		row_t rw;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		in_data = '0;
		arst_n = 0;
		for (int i = 0; i < 3; i++) begin
			m_cen[i] = 0;
			m_vel[i] = 0;
		end
		m_gm = 31'd65536;
		m_rad = 31'd65536;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// After reset: centre at the origin, G*M and radius one.
		rows.push_back('{'{0, 0, 0, 0}, 1, '{-32'sd49151, 1'b1}});
		rows.push_back('{'{32'sh20000, 0, 0, 0}, 1, '{32'sd16384, 1'b0}});
		rows.push_back('{'{32'sh10000, 0, 0, 0}, 1, '{-32'sd16384, 1'b0}});
		rows.push_back('{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 0, '0});
		rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}, 0, '0});
		rows.push_back('{'{32'h80000000, 32'h7fffffff, 0, 32'hffffffff}, 0, '0});
		rows.push_back('{'{1, 0, 0, 0}, 0, '0});
		rows.push_back('{'{32'hffff, 32'hffff, 0, 0}, 0, '0});
		rows.push_back('{'{0, 0, 32'hffff0000, 32'h7fffffff}, 0, '0});
		foreach (rows[i]) send(rows[i].req, rows[i].known, rows[i].res);
		drain();

		// Extremes: moving centre, huge mass, tiny radius, zero radius.
		write_reg(REG_VELOCITY_X, 32'h7fffffff);
		write_reg(REG_VELOCITY_Y, 32'h80000000);
		write_reg(REG_VELOCITY_Z, 32'h00010000);
		write_reg(REG_CENTER_X, 32'h80000000);
		write_reg(REG_CENTER_Y, 32'h7fffffff);
		write_reg(REG_CENTER_Z, 32'h00001234);
		write_reg(REG_GRAVITY_MASS, 32'h7fffffff);
		write_reg(REG_RADIUS, 32'd1);
		rows.delete();
		rows.push_back('{'{32'h80000000, 32'h7fffffff, 32'h1234, 0}, 0, '0});
		rows.push_back('{'{0, 0, 0, 32'h7fffffff}, 0, '0});
		rows.push_back('{'{0, 0, 0, 32'h80000000}, 0, '0});
		foreach (rows[i]) send(rows[i].req, rows[i].known, rows[i].res);
		drain();
		write_reg(REG_RADIUS, 32'd0);
		write_reg(REG_GRAVITY_MASS, 32'd0);
		rw.req = '{32'h80000000, 32'h7fffffff, 32'h1234, 0};
		send(rw.req, 0, '0);
		drain();
		write_reg(REG_GRAVITY_MASS, 32'h7fffffff);
		write_reg(REG_RADIUS, 32'h7fffffff);
		for (int i = 0; i < 6; i++) write_reg(i[2:0], 32'd0);
		send('{0, 0, 0, 0}, 0, '0);
		send('{32'h40000000, 0, 0, 0}, 0, '0);
		drain();

		// Random settings, mostly modest sizes so both branches are reached.
		for (int ph = 0; ph < 5; ph++) begin
			for (int i = 0; i < 3; i++) begin
				write_reg(i[2:0], rnd_coord());
				write_reg(3'(i + 3), (ph == 4) ? $urandom() :
					32'($signed($urandom_range(0, 1 << 17)) - (1 << 16)));
			end
			write_reg(REG_GRAVITY_MASS, (ph == 4) ? $urandom() : $urandom_range(0, 1 << 20));
			write_reg(REG_RADIUS, (ph == 3) ? $urandom() :
				$urandom_range(1 << 14, 1 << 19));
			random_phase(100);
			drain();
		end

		stim_done = 1;
		if (errors == 0 && potential_q.size() == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
